// ----- design/transposition_table_probe_store_top_assert.svh -----
// Assertion macros for the transposition table probe/store block.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_TOP_ASSERT_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TTPS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ttps assertion failed");
`define TTPS_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ttps assertion failed");
`else
`define TTPS_ASSERT(lbl, clk, rst, prop)
`define TTPS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- design/ttps_pkg.sv -----
// Shared types and constants for the transposition table probe/store block.
`timescale 1ns / 1ps
`default_nettype none
package ttps_pkg;

  localparam int unsigned INDEX_BITS_DEFAULT = 12;
  localparam int unsigned KeyIndexW = 12;
  localparam int unsigned CheckW    = 64;
  localparam int unsigned ScoreW    = 32;
  localparam int unsigned DepthW    = 6;
  localparam int unsigned KindW     = 2;

  localparam logic REQ_PROBE = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  localparam logic [KindW-1:0] KIND_EXACT = 2'd0;
  localparam logic [KindW-1:0] KIND_LOWER = 2'd1;
  localparam logic [KindW-1:0] KIND_UPPER = 2'd2;

  typedef struct packed {
    logic                     valid;
    logic [CheckW-1:0]        check;
    logic signed [ScoreW-1:0] score;
    logic [DepthW-1:0]        depth;
    logic [KindW-1:0]         kind;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DELIVER
  } state_t;

endpackage
`default_nettype wire

// ----- design/ttps_ram.sv -----
// Single-port-write, registered-read entry memory for both banks.
`timescale 1ns / 1ps
`default_nettype none
module ttps_ram #(
  parameter int unsigned ADDR_BITS = ttps_pkg::INDEX_BITS_DEFAULT + 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire ttps_pkg::entry_t     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output ttps_pkg::entry_t          rd_data
);
  import ttps_pkg::*;

  localparam int unsigned Depth = 1 << ADDR_BITS;

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- design/transposition_table_probe_store_top.sv -----
// Top level of the two-bank, direct-mapped, always-replace transposition table.
`timescale 1ns / 1ps
`default_nettype none
`include "transposition_table_probe_store_top_assert.svh"
// Two banks (selected by side) of 2^INDEX_BITS slots each, held in one
// memory with a registered read. After reset the block sweeps the memory
// to clear every valid bit, one slot per cycle, over all 2^(INDEX_BITS+1)
// slots; in_ready stays low until it is done. One item is in flight at a
// time: a probe goes from acceptance through the table read, the tag/bound
// check and the output load; a store writes at acceptance and then loads the
// output. The next item is taken only once the result is loaded, and a
// full, stalled output holds the block until the result there is taken.
// Every item gives one result; a store always returns hit=0, value=0.
module transposition_table_probe_store_top #(
  parameter int unsigned INDEX_BITS = ttps_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               req_type,
  input  wire logic                               side,
  input  wire logic [ttps_pkg::KeyIndexW-1:0]     key_index,
  input  wire logic [ttps_pkg::CheckW-1:0]        key_check,
  input  wire logic signed [ttps_pkg::ScoreW-1:0] alpha,
  input  wire logic signed [ttps_pkg::ScoreW-1:0] beta,
  input  wire logic [ttps_pkg::DepthW-1:0]        search_depth,
  input  wire logic signed [ttps_pkg::ScoreW-1:0] score,
  input  wire logic [ttps_pkg::KindW-1:0]         bound_kind,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    hit,
  output logic signed [ttps_pkg::ScoreW-1:0]      value
);
  import ttps_pkg::*;

  localparam int unsigned AddrW = INDEX_BITS + 1;

  state_t state, state_next;

  logic [AddrW-1:0] clr_addr;
  logic             accept;
  logic             out_load;
  logic             res_load;

  // request held for the lookup stage
  logic [CheckW-1:0]        req_check;
  logic signed [ScoreW-1:0] req_alpha;
  logic signed [ScoreW-1:0] req_beta;
  logic [DepthW-1:0]        req_depth;

  logic                     res_hit;
  logic signed [ScoreW-1:0] res_value;
  logic                     res_hit_next;
  logic signed [ScoreW-1:0] res_value_next;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [AddrW-1:0] slot;
  entry_t           rd_data;

  logic probe_match;
  logic bound_ok;

  assign accept = in_valid && in_ready;
  assign slot   = {side, INDEX_BITS'(key_index)};

  ttps_ram #(
    .ADDR_BITS(AddrW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(slot),
    .rd_data(rd_data)
  );

  always_comb begin
    case (rd_data.kind)
      KIND_EXACT: bound_ok = 1'b1;
      KIND_LOWER: bound_ok = rd_data.score >= req_beta;
      KIND_UPPER: bound_ok = rd_data.score <= req_alpha;
      default:    bound_ok = 1'b0;
    endcase
  end

  assign probe_match = rd_data.valid && (rd_data.depth >= req_depth) &&
                       (rd_data.check == req_check) && bound_ok;

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = slot;
    wr_data        = '{valid: 1'b1, check: key_check, score: score,
                       depth: search_depth, kind: bound_kind};
    rd_en          = 1'b0;
    res_load       = 1'b0;
    res_hit_next   = 1'b0;
    res_value_next = '0;
    out_load       = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (req_type == REQ_STORE) begin
            wr_en      = 1'b1;
            res_load   = 1'b1;
            state_next = ST_DELIVER;
          end else begin
            rd_en      = 1'b1;
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        res_load     = 1'b1;
        res_hit_next = probe_match;
        if (probe_match) begin
          res_value_next = rd_data.score;
        end
        state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_check <= key_check;
      req_alpha <= alpha;
      req_beta  <= beta;
      req_depth <= search_depth;
    end
    if (res_load) begin
      res_hit   <= res_hit_next;
      res_value <= res_value_next;
    end
    if (out_load) begin
      hit   <= res_hit;
      value <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // one item in flight: no acceptance right after another
  `TTPS_ASSERT(a_one_in_flight, clk, rst, accept |=> !in_ready)
  // a store always yields a miss result waiting for delivery
  `TTPS_ASSERT(a_store_misses, clk, rst,
    (accept && req_type == REQ_STORE) |=> (state == ST_DELIVER && !res_hit))
  // lookup only follows an accepted probe
  `TTPS_ASSERT(a_lookup_after_probe, clk, rst,
    (state == ST_LOOKUP) |-> $past(accept && req_type == REQ_PROBE))

endmodule
`default_nettype wire

// ----- tb/tb_transposition_table_probe_store_top.sv -----
// Testbench for the two-bank transposition table: directed and random probes/stores.
`timescale 1ns / 1ps
module tb_transposition_table_probe_store_top;
  import ttps_pkg::*;

  localparam int unsigned SLOTS = 2 ** (INDEX_BITS_DEFAULT + 1);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic signed [ScoreW-1:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [ScoreW-1:0] SCORE_MAX = 32'sh7fff_ffff;
  localparam logic [KindW-1:0] KIND_RESERVED = 2'd3;

  typedef struct {
    logic                     req_type;
    logic                     side;
    logic [KeyIndexW-1:0]     key_index;
    logic [CheckW-1:0]        key_check;
    logic signed [ScoreW-1:0] alpha;
    logic signed [ScoreW-1:0] beta;
    logic [DepthW-1:0]        search_depth;
    logic signed [ScoreW-1:0] score;
    logic [KindW-1:0]         bound_kind;
  } tt_req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [ScoreW-1:0] value;
  } tt_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = REQ_PROBE;
  logic side = 1'b0;
  logic [KeyIndexW-1:0] key_index = '0;
  logic [CheckW-1:0] key_check = '0;
  logic signed [ScoreW-1:0] alpha = '0;
  logic signed [ScoreW-1:0] beta = '0;
  logic [DepthW-1:0] search_depth = '0;
  logic signed [ScoreW-1:0] score = '0;
  logic [KindW-1:0] bound_kind = KIND_EXACT;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic signed [ScoreW-1:0] value;

  entry_t     tt_shadow [SLOTS];
  tt_answer_t answer_q [$];
  tt_req_t    recent_stores [$];
  int         mismatches = 0;
  int         cycles = 0;
  int         burst_left = 0;
  int         ready_pct = 100;
  int         ready_phase_left = 0;

  transposition_table_probe_store_top u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .side(side),
    .key_index(key_index),
    .key_check(key_check),
    .alpha(alpha),
    .beta(beta),
    .search_depth(search_depth),
    .score(score),
    .bound_kind(bound_kind),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .value(value)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: ready probability changes phase by phase, 100% gives stall-free stretches.
  always @(posedge clk) begin
    if (ready_phase_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 10;
      endcase
      ready_phase_left = $urandom_range(5, 60);
    end
    ready_phase_left--;
    out_ready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin : answer_check
    tt_answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b value=%0d", $time, hit, value);
        mismatches++;
      end else begin
        want = answer_q.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit mismatch expected %0b actual %0b", $time, want.hit, hit);
          mismatches++;
        end
        if (value !== want.value) begin
          $display("%0t: value mismatch expected %0d actual %0d", $time, want.value, value);
          mismatches++;
        end
      end
    end
  end

  // Shadow table: store always replaces; probe hits on valid, deep enough, same key, usable bound.
  function automatic tt_answer_t score_lookup(input tt_req_t r);
    tt_answer_t ans;
    entry_t     e;
    logic [KeyIndexW:0] slot;
    logic       usable;
    slot = {r.side, r.key_index};
    e = tt_shadow[slot];
    ans = '0;
    usable = 1'b0;
    if (r.req_type == REQ_STORE) begin
      e.valid = 1'b1;
      e.check = r.key_check;
      e.score = r.score;
      e.depth = r.search_depth;
      e.kind = r.bound_kind;
      tt_shadow[slot] = e;
    end else if (e.valid && e.depth >= r.search_depth && e.check == r.key_check) begin
      case (e.kind)
        KIND_EXACT: usable = 1'b1;
        KIND_LOWER: usable = ($signed(e.score) >= $signed(r.beta));
        KIND_UPPER: usable = ($signed(e.score) <= $signed(r.alpha));
        default: usable = 1'b0;
      endcase
      if (usable) begin
        ans.hit = 1'b1;
        ans.value = e.score;
      end
    end
    return ans;
  endfunction

  function automatic logic [CheckW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [ScoreW-1:0] rand_score();
    case ($urandom_range(0, 9))
      0: return SCORE_MIN;
      1: return SCORE_MAX;
      2, 3, 4: return $signed(32'($urandom_range(0, 200))) - 32'sd100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [ScoreW-1:0] near_score(input logic signed [ScoreW-1:0] s);
    case ($urandom_range(0, 4))
      0: return s - 32'sd1;
      1: return s;
      2: return s + 32'sd1;
      3: return rand_score();
      default: return $urandom;
    endcase
  endfunction

  // Fields a request does not use still carry random bits.
  function automatic tt_req_t mk_store(input logic s, input logic [KeyIndexW-1:0] idx,
                                       input logic [CheckW-1:0] chk,
                                       input logic signed [ScoreW-1:0] sc,
                                       input logic [DepthW-1:0] dp, input logic [KindW-1:0] kd);
    tt_req_t r;
    r.req_type = REQ_STORE;
    r.side = s;
    r.key_index = idx;
    r.key_check = chk;
    r.alpha = $urandom;
    r.beta = $urandom;
    r.search_depth = dp;
    r.score = sc;
    r.bound_kind = kd;
    return r;
  endfunction

  function automatic tt_req_t mk_probe(input logic s, input logic [KeyIndexW-1:0] idx,
                                       input logic [CheckW-1:0] chk,
                                       input logic signed [ScoreW-1:0] a,
                                       input logic signed [ScoreW-1:0] b,
                                       input logic [DepthW-1:0] dp);
    tt_req_t r;
    r.req_type = REQ_PROBE;
    r.side = s;
    r.key_index = idx;
    r.key_check = chk;
    r.alpha = a;
    r.beta = b;
    r.search_depth = dp;
    r.score = $urandom;
    r.bound_kind = KindW'($urandom_range(0, 3));
    return r;
  endfunction

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic send_req(input tt_req_t r);
    pace_sender();
    in_valid <= 1'b1;
    req_type <= r.req_type;
    side <= r.side;
    key_index <= r.key_index;
    key_check <= r.key_check;
    alpha <= r.alpha;
    beta <= r.beta;
    search_depth <= r.search_depth;
    score <= r.score;
    bound_kind <= r.bound_kind;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    answer_q.push_back(score_lookup(r));
    if (r.req_type == REQ_STORE) begin
      recent_stores.push_back(r);
      if (recent_stores.size() > 32) void'(recent_stores.pop_front());
    end
  endtask

  // Always waits on the clock before polling the answer queue, so in_valid is never lowered and raised in one step.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_slots();
    send_req(mk_probe(1'b0, 12'd0, 64'd0, SCORE_MAX, SCORE_MIN, 6'd0));
    send_req(mk_probe(1'b1, 12'hfff, '1, SCORE_MAX, SCORE_MIN, 6'd0));
  endtask

  task automatic test_exact_entry();
    send_req(mk_store(1'b0, 12'd0, '1, SCORE_MIN, 6'd20, KIND_EXACT));
    send_req(mk_probe(1'b0, 12'd0, '1, 32'sd0, 32'sd0, 6'd20));
    send_req(mk_probe(1'b0, 12'd0, '1, 32'sd0, 32'sd0, 6'd21));
    send_req(mk_probe(1'b0, 12'd0, 64'hffff_ffff_ffff_fffe, 32'sd0, 32'sd0, 6'd0));
    // same index, other bank: untouched
    send_req(mk_probe(1'b1, 12'd0, '1, 32'sd0, 32'sd0, 6'd0));
  endtask

  task automatic test_bound_kinds();
    send_req(mk_store(1'b1, 12'hfff, 64'h0123_4567_89ab_cdef, 32'sd100, 6'd63, KIND_LOWER));
    send_req(mk_probe(1'b1, 12'hfff, 64'h0123_4567_89ab_cdef, SCORE_MIN, 32'sd100, 6'd63));
    send_req(mk_probe(1'b1, 12'hfff, 64'h0123_4567_89ab_cdef, SCORE_MIN, 32'sd101, 6'd63));
    send_req(mk_store(1'b1, 12'd7, 64'hdead_beef_0000_0001, -32'sd5, 6'd0, KIND_UPPER));
    send_req(mk_probe(1'b1, 12'd7, 64'hdead_beef_0000_0001, -32'sd5, SCORE_MAX, 6'd0));
    send_req(mk_probe(1'b1, 12'd7, 64'hdead_beef_0000_0001, -32'sd6, SCORE_MAX, 6'd0));
    // reserved kind is stored but never usable
    send_req(mk_store(1'b0, 12'h800, 64'h5555_aaaa_5555_aaaa, 32'sd0, 6'd10, KIND_RESERVED));
    send_req(mk_probe(1'b0, 12'h800, 64'h5555_aaaa_5555_aaaa, SCORE_MAX, SCORE_MIN, 6'd0));
  endtask

  task automatic test_score_extremes();
    send_req(mk_store(1'b0, 12'd1, 64'd0, SCORE_MAX, 6'd63, KIND_EXACT));
    send_req(mk_probe(1'b0, 12'd1, 64'd0, SCORE_MIN, SCORE_MAX, 6'd63));
    send_req(mk_store(1'b1, 12'd2, 64'd2, SCORE_MIN, 6'd5, KIND_LOWER));
    send_req(mk_probe(1'b1, 12'd2, 64'd2, SCORE_MAX, SCORE_MIN, 6'd5));
  endtask

  task automatic test_overwrite();
    send_req(mk_store(1'b0, 12'd0, 64'h1234_5678_9abc_def0, 32'sd7, 6'd5, KIND_EXACT));
    send_req(mk_probe(1'b0, 12'd0, '1, 32'sd0, 32'sd0, 6'd0));
    send_req(mk_probe(1'b0, 12'd0, 64'h1234_5678_9abc_def0, 32'sd0, 32'sd0, 6'd5));
  endtask

  task automatic test_random_traffic(input int n_items);
    tt_req_t r;
    tt_req_t prev;
    logic [KeyIndexW-1:0] idx;
    logic [KindW-1:0] kd;
    int pick;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_for_answers();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // hot indexes make overwrites and later hits likely
        idx = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                          : 12'($urandom_range(0, 15) * 257);
        case ($urandom_range(0, 9))
          0, 1, 2: kd = KIND_EXACT;
          3, 4, 5: kd = KIND_LOWER;
          6, 7, 8: kd = KIND_UPPER;
          default: kd = KIND_RESERVED;
        endcase
        r = mk_store(1'($urandom_range(0, 1)), idx, rand_key(), rand_score(),
                     DepthW'($urandom_range(0, 63)), kd);
      end else if (pick < 85 && recent_stores.size() != 0) begin
        prev = recent_stores[$urandom_range(0, recent_stores.size() - 1)];
        r = mk_probe(prev.side, prev.key_index, prev.key_check, near_score(prev.score),
                     near_score(prev.score),
                     DepthW'($urandom_range(0, prev.search_depth)));
        case ($urandom_range(0, 9))
          0: r.key_check[$urandom_range(0, CheckW - 1)] ^= 1'b1;
          1: r.search_depth = (prev.search_depth == 6'd63) ? 6'd63 : prev.search_depth + 6'd1;
          2: r.side = ~prev.side;
          default: ;
        endcase
      end else begin
        r = mk_probe(1'($urandom_range(0, 1)), KeyIndexW'($urandom_range(0, 4095)),
                     rand_key(), $urandom, $urandom, DepthW'($urandom_range(0, 63)));
      end
      send_req(r);
    end
  endtask

  initial begin
    foreach (tt_shadow[i]) tt_shadow[i].valid = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_slots();
    test_exact_entry();
    test_bound_kinds();
    test_score_extremes();
    test_overwrite();
    test_random_traffic(700);
    in_valid <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
